// ===== rtl/rhsl_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rhsl_pkg
// Shared widths, types and the divider step for the RGB to HSL converter.
// ---------------------------------------------------------------------------
package rhsl_pkg;

  // channel and result widths
  localparam int CH_W  = 8;
  localparam int FLD_W = 16;

  // divider geometry: divisor up to 6*255, quotient up to 2^16
  localparam int DEN_W = 11;
  localparam int QUO_W = 17;
  localparam int NUM_W = DEN_W - 1 + QUO_W;

  // divider lanes
  localparam int LANES    = 2;
  localparam int LANE_HUE = 0;
  localparam int LANE_SAT = 1;

  // one lane of the long division: partial remainder, numerator bits that
  // are still to be brought down (quotient bits fill in from the bottom)
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] work;
    logic [DEN_W-1:0] dvsr;
  } div_lane_t;

  typedef div_lane_t [LANES-1:0] lanes_t;

  // data that rides along the divider
  typedef struct packed {
    logic             grey;
    logic [FLD_W-1:0] light;
  } side_t;

  // one restoring division step on one lane
  function automatic div_lane_t div_step(div_lane_t x);
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;
    div_lane_t      y;
    trial  = {x.rem, x.work[QUO_W-1]};
    diff   = trial - {1'b0, x.dvsr};
    ge     = (trial >= {1'b0, x.dvsr});
    y.dvsr = x.dvsr;
    y.rem  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    y.work = {x.work[QUO_W-2:0], ge};
    return y;
  endfunction

  // step every lane
  function automatic lanes_t div_step_all(lanes_t x);
    lanes_t y;
    for (int i = 0; i < LANES; i++) begin
      y[i] = div_step(x[i]);
    end
    return y;
  endfunction

endpackage

// ===== rtl/rhsl_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rhsl_div
// Pipelined restoring divider, one quotient bit per stage on every lane.
// ---------------------------------------------------------------------------
module rhsl_div
  import rhsl_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  lanes_t in_lanes,
  input  side_t  in_side,
  output logic   out_valid,
  output lanes_t out_lanes,
  output side_t  out_side
);

  logic [QUO_W-1:0] vld;
  lanes_t           stg  [QUO_W];
  side_t            side [QUO_W];

  // valid bits travel with the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QUO_W-2:0], in_valid};
    end
  end

  // one division step per stage
  always_ff @(posedge clk) begin
    if (en) begin
      stg[0]  <= div_step_all(in_lanes);
      side[0] <= in_side;
      for (int s = 1; s < QUO_W; s++) begin
        stg[s]  <= div_step_all(stg[s-1]);
        side[s] <= side[s-1];
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign out_lanes = stg[QUO_W-1];
  assign out_side  = side[QUO_W-1];

endmodule

// ===== rtl/rgb_to_hsl_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_to_hsl_core
// RGB pixel to hue, saturation and lightness in unsigned Q0.16.
// ---------------------------------------------------------------------------
// Takes one pixel per clock while the output side does not stall and returns
// one result per pixel, in order: two front stages find max, min and the hue
// sector, then 17 stages of a restoring divider (one quotient bit per stage,
// hue and saturation side by side), then the output register. A request is
// held in a one-entry skid buffer when the output side stalls, so
// s_axis_tready is a register.
// ---------------------------------------------------------------------------
module rgb_to_hsl_core
  import rhsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // hue[15:0], saturation[31:16], lightness[47:32]
);

  logic        en;
  logic        skid_valid;
  logic [23:0] skid_data;
  logic        src_valid;
  logic [23:0] src_data;

  // pipeline advances unless the result is stuck
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !skid_valid;

  // skid buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && !skid_valid && s_axis_tvalid) begin
      skid_data <= s_axis_tdata;
    end
  end

  assign src_valid = skid_valid || s_axis_tvalid;
  assign src_data  = skid_valid ? skid_data : s_axis_tdata;

  // stage a: max, min, dominant channel
  logic [CH_W-1:0]   r, g, b, hi, lo, d_a;
  logic signed [11:0] diff_a, t0_a;
  logic [CH_W:0]      sum_a;

  always_comb begin
    r      = src_data[7:0];
    g      = src_data[15:8];
    b      = src_data[23:16];
    hi     = (r > g) ? r : g;
    hi     = (hi > b) ? hi : b;
    lo     = (r < g) ? r : g;
    lo     = (lo < b) ? lo : b;
    d_a    = hi - lo;
    sum_a  = {1'b0, hi} + {1'b0, lo};
    priority if (r == hi) begin
      diff_a = $signed({4'b0, g}) - $signed({4'b0, b});
      t0_a   = diff_a;
    end else if (g == hi) begin
      diff_a = $signed({4'b0, b}) - $signed({4'b0, r});
      t0_a   = diff_a + $signed({3'b0, d_a, 1'b0});
    end else begin
      diff_a = $signed({4'b0, r}) - $signed({4'b0, g});
      t0_a   = diff_a + $signed({2'b0, d_a, 2'b0});
    end
  end

  logic               a_valid;
  logic [CH_W-1:0]    a_d;
  logic [CH_W:0]      a_sum;
  logic signed [11:0] a_t0;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d   <= d_a;
      a_sum <= sum_a;
      a_t0  <= t0_a;
    end
  end

  // stage b: lightness, wrapped hue offset, divider operands
  logic [16:0]        l17;
  logic [DEN_W-1:0]   six_d;
  logic [9:0]         three_d;
  logic signed [11:0] u_s;
  logic [DEN_W-1:0]   u;
  logic [CH_W-1:0]    den;
  logic [NUM_W-1:0]   hue_num;
  logic [NUM_W-1:0]   sat_num;
  logic [CH_W:0]      den_hi;
  lanes_t             lanes_b;
  side_t              side_b;

  always_comb begin
    l17     = {a_sum, 8'b0} + {8'b0, a_sum} + 17'd1;
    six_d   = {1'b0, a_d, 2'b0} + {2'b0, a_d, 1'b0};
    three_d = {1'b0, a_d, 1'b0} + {2'b0, a_d};
    u_s     = (a_t0 < 0) ? (a_t0 + $signed({1'b0, six_d})) : a_t0;
    u       = u_s[DEN_W-1:0];
    den_hi  = 9'd510 - a_sum;
    den     = (a_sum < 9'd255) ? a_sum[CH_W-1:0] : den_hi[CH_W-1:0];
    hue_num = {u, 16'b0} + {17'b0, three_d};
    sat_num = {2'b0, a_d, 17'b0} - {18'b0, a_d, 1'b0} + {19'b0, den};

    lanes_b[LANE_HUE].rem  = {1'b0, hue_num[NUM_W-1:QUO_W]};
    lanes_b[LANE_HUE].work = hue_num[QUO_W-1:0];
    lanes_b[LANE_HUE].dvsr = six_d;
    lanes_b[LANE_SAT].rem  = {1'b0, sat_num[NUM_W-1:QUO_W]};
    lanes_b[LANE_SAT].work = sat_num[QUO_W-1:0];
    lanes_b[LANE_SAT].dvsr = {2'b0, den, 1'b0};

    side_b.grey  = (a_d == '0);
    side_b.light = l17[16:1];
  end

  logic   b_valid;
  lanes_t b_lanes;
  side_t  b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_lanes <= lanes_b;
      b_side  <= side_b;
    end
  end

  // divider
  logic   q_valid;
  lanes_t q_lanes;
  side_t  q_side;

  rhsl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_valid),
    .in_lanes  (b_lanes),
    .in_side   (b_side),
    .out_valid (q_valid),
    .out_lanes (q_lanes),
    .out_side  (q_side)
  );

  // output register: grey masking, hue wrap, saturation clamp
  logic [QUO_W-1:0] hue_q, sat_q;
  logic [FLD_W-1:0] hue_o, sat_o;

  always_comb begin
    hue_q = q_lanes[LANE_HUE].work;
    sat_q = q_lanes[LANE_SAT].work;
    hue_o = q_side.grey ? '0 : hue_q[FLD_W-1:0];
    if (q_side.grey) begin
      sat_o = '0;
    end else if (sat_q[QUO_W-1]) begin
      sat_o = '1;
    end else begin
      sat_o = sat_q[FLD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {q_side.light, sat_o, hue_o};
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGB to HSL pixel converter.
// ---------------------------------------------------------------------------
// Pixels go in through the input stream and each accepted request is run
// through a local integer model of the conversion. The expected hue,
// saturation and lightness wait in order until the output stream returns
// them. Both sides stall at random. There is also a long output hold-off
// that backs the pipeline up, a pause that drains it, and a stretch with no
// idling at all. Corner pixels come first, then random pixels weighted
// toward grey, ties and the ends of the channel range.
// ---------------------------------------------------------------------------
module testbench;
  import rhsl_pkg::*;

  typedef struct packed {
    logic [FLD_W-1:0] hue;
    logic [FLD_W-1:0] sat;
    logic [FLD_W-1:0] light;
  } hsl_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // hue[15:0], saturation[31:16], lightness[47:32]

  hsl_t pending_hsl[$];
  int   mismatch_count = 0;
  bit   steady = 1'b0;              // no idling on either side while set
  int   rx_hold_len = 0;            // hold-off asked by a test
  int   rx_hold_left = 0;           // hold-off cycles still to go
  hsl_t want;

  rgb_to_hsl_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  always #5 clk = ~clk;

  // expected conversion of one pixel, exact integer arithmetic
  function automatic hsl_t hsl_of_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    longint hi, lo, d, sum, den, k, diff, n, q;
    hsl_t   res;
    hi  = (r > g) ? longint'(r) : longint'(g);
    hi  = (hi > longint'(b)) ? hi : longint'(b);
    lo  = (r < g) ? longint'(r) : longint'(g);
    lo  = (lo < longint'(b)) ? lo : longint'(b);
    d   = hi - lo;
    sum = hi + lo;
    res.light = 16'((sum * 257 + 1) >>> 1);
    res.hue   = '0;
    res.sat   = '0;
    if (d != 0) begin
      den = (sum < 255) ? sum : (510 - sum);
      q   = (2 * d * 65535 + den) / (2 * den);
      res.sat = (q > 65535) ? 16'hFFFF : q[15:0];
      // dominant channel picks the sector, ties go red then green
      if (r == hi) begin
        k    = 0;
        diff = longint'(g) - longint'(b);
      end else if (g == hi) begin
        k    = 2;
        diff = longint'(b) - longint'(r);
      end else begin
        k    = 4;
        diff = longint'(r) - longint'(g);
      end
      // one full turn added so the numerator stays positive
      n = (k * d + diff + 6 * d) * 65536;
      q = (2 * n + 6 * d) / (12 * d);
      res.hue = q[15:0];
    end
    return res;
  endfunction

  // offer one pixel, with a random gap before it unless steady
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 13) begin
      gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    do @(posedge clk); while (!s_axis_tready);
    pending_hsl.push_back(hsl_of_pixel(r, g, b));
  endtask

  // channel value weighted toward the ends of the range
  function automatic logic [7:0] pick_channel();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return $urandom_range(1) ? 8'd1 : 8'd254;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // random pixel with grey and tie cases mixed in
  task automatic send_random_pixel();
    logic [7:0] r, g, b;
    r = pick_channel();
    g = pick_channel();
    b = pick_channel();
    case ($urandom_range(9))
      0: begin
        g = r;
        b = r;
      end
      1: g = r;
      2: b = g;
      3: b = r;
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  // corners, every hue sector, ties and the lightness midpoint
  task automatic test_directed();
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd100, 8'd200, 8'd50);
    send_pixel(8'd50,  8'd100, 8'd200);
    send_pixel(8'd200, 8'd50,  8'd100);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd2,   8'd0,   8'd1);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd254, 8'd0,   8'd0);
    send_pixel(8'd255, 8'd1,   8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd170, 8'd85,  8'd85);
    send_pixel(8'd85,  8'd170, 8'd170);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_random_pixel();
  endtask

  // output held off for a long stretch while requests keep coming
  task automatic test_backpressure();
    steady      = 1'b1;
    rx_hold_len = 300;
    repeat (80) send_random_pixel();
    steady      = 1'b0;
  endtask

  // sender stops until every result is back, twice
  task automatic test_drain_pause();
    repeat (2) begin
      repeat (30) send_random_pixel();
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while (pending_hsl.size() != 0) @(posedge clk);
    end
  endtask

  // back to back on both sides
  task automatic test_burst();
    steady = 1'b1;
    repeat (150) send_random_pixel();
    steady = 1'b0;
  endtask

  // output side ready, with a counted hold-off on request
  always @(posedge clk) begin
    if (rx_hold_len > 0) begin
      rx_hold_left = rx_hold_len;
      rx_hold_len  = 0;
    end
    if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left--;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 25);
    end
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
      end
    end
  endtask

  // compare each returned result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_hsl.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result with nothing expected, data %h", $realtime, m_axis_tdata);
        end
      end else begin
        want = pending_hsl.pop_front();
        check_field("hue", want.hue, m_axis_tdata[15:0]);
        check_field("saturation", want.sat, m_axis_tdata[31:16]);
        check_field("lightness", want.light, m_axis_tdata[47:32]);
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400);
    test_backpressure();
    test_drain_pause();
    test_burst();
    test_random(400);
    s_axis_tvalid <= 1'b0;
    while (pending_hsl.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_hsl.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
